FILE: rtl/tvdg_pkg.sv
// Shared types and constants for the TV denoise gradient unit.
package tvdg_pkg;

   localparam int unsigned DefaultMaxRows = 256;
   localparam int unsigned DefaultMaxCols = 256;
   localparam int unsigned PixW   = 18;
   localparam int unsigned DiffW  = 19;
   localparam int unsigned MagW   = 27;   // |z| << 8
   localparam int unsigned RadW   = 54;   // z16^2 + eps^2
   localparam int unsigned RootW  = 27;
   localparam int unsigned QuoW   = 17;   // quotient clipped to 65536
   localparam int unsigned DivNW  = 43;   // z16 << 16 plus half divisor
   localparam int unsigned HW     = 18;   // signed H term
   localparam int unsigned GradW  = 32;
   localparam int unsigned SumW   = 37;

   typedef enum logic [3:0] {
      CSR_MU   = 4'd0,
      CSR_EPS  = 4'd1,
      CSR_ROWS = 4'd2,
      CSR_COLS = 4'd3
   } csr_index_type;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_COMPUTE = 1'b1;

   typedef struct packed {
      logic                    start;
      logic signed [DiffW-1:0] diff;
      logic [15:0]             eps;
   } smooth_req_type;

   typedef struct packed {
      logic                 done;
      logic signed [HW-1:0] h_val;
   } smooth_rsp_type;

endpackage

FILE: rtl/tvdg_pixel_store.sv
// Frame store of estimate and noisy pixels, registered synchronous read.
module tvdg_pixel_store
   import tvdg_pkg::*;
#(
   parameter int unsigned AddrW = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrW-1:0]     wr_addr,
   input  logic [2*PixW-1:0]    wr_data,
   input  logic [AddrW-1:0]     rd_addr,
   output logic [2*PixW-1:0]    rd_data
);

   logic [2*PixW-1:0] mem [(1<<AddrW)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/tvdg_smooth_sign.sv
// Iterative z/sqrt(z^2+eps^2): bit-serial square root then restoring divide.
module tvdg_smooth_sign
   import tvdg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  smooth_req_type req,
   output smooth_rsp_type rsp
);

   typedef enum logic [4:0] {
      SS_IDLE = 5'b00001,
      SS_SQR  = 5'b00010,
      SS_ROOT = 5'b00100,
      SS_DIV  = 5'b01000,
      SS_DONE = 5'b10000
   } ss_state_type;

   ss_state_type         state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic [MagW-1:0]      z16_ff, z16_in;
   logic [15:0]          eps_ff, eps_in;
   logic [RadW-1:0]      rad_ff, rad_in;
   logic [RootW-1:0]     root_ff, root_in;
   logic [RadW+1:0]      rem_ff, rem_in;
   logic [DivNW-1:0]     num_ff, num_in;
   logic [DivNW-1:0]     quo_ff, quo_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DiffW-1:0]     mag;
   logic [RootW+1:0]     trial;
   logic [RadW+1:0]      rem_sh;
   logic [DivNW:0]       drem_sh;
   logic [QuoW-1:0]      qclip;

   assign mag = req.diff[DiffW-1] ? DiffW'(-req.diff) : DiffW'(req.diff);

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      z16_in   = z16_ff;
      eps_in   = eps_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      trial    = '0;
      rem_sh   = '0;
      drem_sh  = '0;
      case (state_ff)
         SS_IDLE: begin
            if (req.start) begin
               neg_in   = req.diff[DiffW-1];
               z16_in   = MagW'({mag, 8'd0});
               eps_in   = req.eps;
               state_in = SS_SQR;
            end
         end
         SS_SQR: begin
            rad_in   = RadW'(z16_ff * z16_ff) + RadW'(eps_ff * eps_ff);
            root_in  = '0;
            rem_in   = '0;
            cnt_in   = 6'(RootW);
            state_in = SS_ROOT;
         end
         SS_ROOT: begin
            // one result bit per cycle, two radicand bits consumed
            rem_sh = {rem_ff[RadW-1:0], rad_ff[RadW-1 -: 2]};
            trial  = {root_ff, 2'b01};
            rad_in = {rad_ff[RadW-3:0], 2'b00};
            if (rem_sh >= (RadW+2)'(trial)) begin
               rem_in  = rem_sh - (RadW+2)'(trial);
               root_in = {root_ff[RootW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RootW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = SS_DIV;
            end
         end
         SS_DIV: begin
            if (cnt_ff == 6'd0 && root_ff != '0) begin
               num_in = DivNW'({z16_ff, 16'd0}) + DivNW'(root_ff >> 1);
               quo_in = '0;
               rem_in = '0;
               cnt_in = 6'(DivNW);
               if (root_ff == '0) state_in = SS_DONE;
            end else if (root_ff == '0) begin
               quo_in   = '0;
               state_in = SS_DONE;
            end else begin
               drem_sh = {rem_ff[DivNW-1:0], num_ff[DivNW-1]};
               num_in  = {num_ff[DivNW-2:0], 1'b0};
               if (drem_sh >= (DivNW+1)'(root_ff)) begin
                  rem_in = (RadW+2)'(drem_sh - (DivNW+1)'(root_ff));
                  quo_in = {quo_ff[DivNW-2:0], 1'b1};
               end else begin
                  rem_in = (RadW+2)'(drem_sh);
                  quo_in = {quo_ff[DivNW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_in = SS_DONE;
            end
         end
         SS_DONE: begin
            state_in = SS_IDLE;
         end
         default: state_in = SS_IDLE;
      endcase
   end

   assign qclip = (quo_ff > DivNW'(65536)) ? QuoW'(65536) : QuoW'(quo_ff);
   assign rsp.done  = (state_ff == SS_DONE);
   assign rsp.h_val = neg_ff ? -HW'(qclip) : HW'(qclip);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      neg_ff  <= neg_in;
      z16_ff  <= z16_in;
      eps_ff  <= eps_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
   end

endmodule

FILE: rtl/tv_denoise_gradient_unit.sv
// Top level of the total-variation denoise gradient unit.
//
// Request channel (req_*): action 0 loads x and b at (row, col) into the
// frame store; action 1 asks for the gradient at (row, col). Requests with
// row or col outside the sizes in use are dropped without a response.
// Response channel (rsp_*): row, col, Q16.16 gradient and a saturation flag.
// Configuration (csr_*): write mu, epsilon, rows and cols in use while idle.
// A load passes through a load state before idle. A compute reads five
// pixels from the frame store (one read per cycle), then runs up to four
// smoothed-sign terms through one shared unit (the right and down terms
// reuse the left and up ones at the far border): each needs 27 square-root
// steps and 43 divide steps. The frame store read port and the shared unit
// set how long a compute takes. One request is in flight at a time.
// Reset clears control state and restores the register defaults; the store
// content is undefined until written. When the receiver stalls, the
// response holds in its output register and the next request is still
// accepted and processed; its response waits until the register frees.
module tv_denoise_gradient_unit
   import tvdg_pkg::*;
#(
   parameter int unsigned MAX_ROWS = DefaultMaxRows,
   parameter int unsigned MAX_COLS = DefaultMaxCols
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [7:0]               req_row,
   input  logic [7:0]               req_col,
   input  logic signed [PixW-1:0]   req_x_value,
   input  logic signed [PixW-1:0]   req_b_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_row,
   output logic [7:0]               rsp_out_col,
   output logic signed [GradW-1:0]  rsp_gradient_value,
   output logic                     rsp_saturated,
   input  logic                     csr_write,
   input  logic [3:0]               csr_index,
   input  logic [15:0]              csr_data
);

   localparam int unsigned RowW  = $clog2(MAX_ROWS);
   localparam int unsigned ColW  = $clog2(MAX_COLS);
   localparam int unsigned AddrW = RowW + ColW;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RD    = 9'b000000010,
      ST_WAIT  = 9'b000000100,
      ST_TERM  = 9'b000001000,
      ST_BUSY  = 9'b000010000,
      ST_MUL   = 9'b000100000,
      ST_SUM   = 9'b001000000,
      ST_OUT   = 9'b010000000,
      ST_LOAD  = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [15:0]             mu_ff, eps_ff;
   logic [8:0]              rows_ff, cols_ff;
   logic [7:0]              row_ff, col_ff;
   logic [2:0]              rd_cnt_ff, rd_cnt_in;
   logic [2:0]              cap_cnt_ff, cap_cnt_in;
   logic [1:0]              term_ff, term_in;
   logic signed [PixW-1:0]  xc_ff, bc_ff, xl_ff, xr_ff, xu_ff, xd_ff;
   logic signed [HW-1:0]    hl_ff, hr_ff, vu_ff, vd_ff;
   logic signed [SumW-1:0]  fid_ff, sum_ff;
   logic                    rd_pend_ff;
   logic                    ovalid_ff;
   logic [7:0]              orow_ff, ocol_ff;
   logic signed [GradW-1:0] ograd_ff;
   logic                    osat_ff;
   logic [8:0]              nr, nc;
   logic                    in_range, req_take;
   logic                    st_wen;
   logic [AddrW-1:0]        st_waddr, st_raddr;
   logic [2*PixW-1:0]       st_rdata;
   logic [RowW-1:0]         rd_row;
   logic [ColW-1:0]         rd_col;
   logic                    has_left, has_right, has_up, has_down;
   smooth_req_type          ss_req;
   smooth_rsp_type          ss_rsp;
   logic signed [PixW:0]    d_l, d_r, d_u, d_d;
   logic signed [GradW-1:0] sat_val;
   logic                    sat_flag;

   assign nr = (int'(rows_ff) < MAX_ROWS) ? rows_ff : 9'(MAX_ROWS);
   assign nc = (int'(cols_ff) < MAX_COLS) ? cols_ff : 9'(MAX_COLS);
   assign in_range = (9'(req_row) < nr) && (9'(req_col) < nc);

   // accept only when idle
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign has_left  = (col_ff != 8'd0);
   assign has_right = (9'(col_ff) + 9'd1 < nc);
   assign has_up    = (row_ff != 8'd0);
   assign has_down  = (9'(row_ff) + 9'd1 < nr);

   assign st_wen   = req_take && in_range && (req_action == ACT_LOAD);
   assign st_waddr = {RowW'(req_row), ColW'(req_col)};

   // read sequence: center, left, right, up, down
   always_comb begin
      rd_row = RowW'(row_ff);
      rd_col = ColW'(col_ff);
      case (rd_cnt_ff)
         3'd1: rd_col = ColW'(col_ff) - ColW'(1);
         3'd2: rd_col = ColW'(col_ff) + ColW'(1);
         3'd3: rd_row = RowW'(row_ff) - RowW'(1);
         3'd4: rd_row = RowW'(row_ff) + RowW'(1);
         default: ;
      endcase
   end
   assign st_raddr = {rd_row, rd_col};

   tvdg_pixel_store #(.AddrW(AddrW)) u_store (
      .clock   (clock),
      .wr_en   (st_wen),
      .wr_addr (st_waddr),
      .wr_data ({req_b_value, req_x_value}),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign d_l = has_left ? (PixW+1)'(xl_ff) - (PixW+1)'(xc_ff) : '0;
   assign d_r = (PixW+1)'(xc_ff) - (PixW+1)'(xr_ff);
   assign d_u = has_up ? (PixW+1)'(xu_ff) - (PixW+1)'(xc_ff) : '0;
   assign d_d = (PixW+1)'(xc_ff) - (PixW+1)'(xd_ff);

   always_comb begin
      ss_req.start = (state_ff == ST_TERM);
      ss_req.eps   = eps_ff;
      case (term_ff)
         2'd0: ss_req.diff = d_l;
         2'd1: ss_req.diff = d_r;
         2'd2: ss_req.diff = d_u;
         default: ss_req.diff = d_d;
      endcase
   end

   tvdg_smooth_sign u_smooth (
      .clock (clock),
      .reset (reset),
      .req   (ss_req),
      .rsp   (ss_rsp)
   );

   always_comb begin
      if (sum_ff > SumW'(signed'(32'sh7FFFFFFF))) begin
         sat_val = 32'sh7FFFFFFF; sat_flag = 1'b1;
      end else if (sum_ff < -SumW'(signed'(33'sh080000000))) begin
         sat_val = 32'sh80000000; sat_flag = 1'b1;
      end else begin
         sat_val = GradW'(sum_ff); sat_flag = 1'b0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      rd_cnt_in  = rd_cnt_ff;
      cap_cnt_in = cap_cnt_ff;
      term_in    = term_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && in_range) begin
               if (req_action == ACT_COMPUTE) begin
                  state_in = ST_RD; rd_cnt_in = '0; cap_cnt_in = '0;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         ST_RD: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'd4) state_in = ST_WAIT;
            if (rd_pend_ff) cap_cnt_in = cap_cnt_ff + 3'd1;
         end
         ST_WAIT: begin
            term_in = 2'd0; state_in = ST_TERM;
         end
         ST_TERM: state_in = ST_BUSY;
         ST_BUSY: begin
            if (ss_rsp.done) begin
               term_in = term_ff + 2'd1;
               if (term_ff == 2'd3) state_in = ST_MUL;
               else if (term_ff == 2'd0 && !has_right) begin
                  term_in = 2'd2; state_in = ST_TERM;
               end else if (term_ff == 2'd2 && !has_down) state_in = ST_MUL;
               else state_in = ST_TERM;
            end
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: state_in = ST_OUT;
         ST_OUT: if (!ovalid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mu_ff      <= 16'd256;
         eps_ff     <= 16'd655;
         rows_ff    <= 9'd256;
         cols_ff    <= 9'd256;
         ovalid_ff  <= 1'b0;
         rd_pend_ff <= 1'b0;
         rd_cnt_ff  <= '0;
         cap_cnt_ff <= '0;
         term_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rd_cnt_ff  <= rd_cnt_in;
         cap_cnt_ff <= cap_cnt_in;
         term_ff    <= term_in;
         rd_pend_ff <= (state_ff == ST_RD);
         if (csr_write) begin
            case (csr_index)
               CSR_MU:   mu_ff   <= csr_data;
               CSR_EPS:  eps_ff  <= csr_data;
               CSR_ROWS: rows_ff <= csr_data[8:0];
               CSR_COLS: cols_ff <= csr_data[8:0];
               default: ;
            endcase
         end
         // load a new response, else drop the one just taken
         if (state_ff == ST_OUT && (!ovalid_ff || !rsp_stall)) begin
            ovalid_ff <= 1'b1;
         end else if (ovalid_ff && !rsp_stall) begin
            ovalid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      // capture store data in the cycle after each read
      if (rd_pend_ff) begin
         case (cap_cnt_ff)
            3'd0: begin
               xc_ff <= st_rdata[PixW-1:0];
               bc_ff <= st_rdata[2*PixW-1:PixW];
            end
            3'd1: xl_ff <= st_rdata[PixW-1:0];
            3'd2: xr_ff <= st_rdata[PixW-1:0];
            3'd3: xu_ff <= st_rdata[PixW-1:0];
            default: xd_ff <= st_rdata[PixW-1:0];
         endcase
      end
      if (state_ff == ST_BUSY && ss_rsp.done) begin
         case (term_ff)
            2'd0: begin
               hl_ff <= ss_rsp.h_val;
               if (!has_right) hr_ff <= ss_rsp.h_val;
            end
            2'd1: hr_ff <= ss_rsp.h_val;
            2'd2: begin
               vu_ff <= ss_rsp.h_val;
               if (!has_down) vd_ff <= ss_rsp.h_val;
            end
            default: vd_ff <= ss_rsp.h_val;
         endcase
      end
      if (state_ff == ST_MUL) begin
         fid_ff <= SumW'($signed({1'b0, mu_ff}) *
                         ((PixW+1)'(xc_ff) - (PixW+1)'(bc_ff)));
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= fid_ff - SumW'(hl_ff) + SumW'(hr_ff)
                          - SumW'(vu_ff) + SumW'(vd_ff);
      end
      if (state_ff == ST_OUT && (!ovalid_ff || !rsp_stall)) begin
         orow_ff  <= row_ff;
         ocol_ff  <= col_ff;
         ograd_ff <= sat_val;
         osat_ff  <= sat_flag;
      end
   end

   assign rsp_valid          = ovalid_ff;
   assign rsp_out_row        = orow_ff;
   assign rsp_out_col        = ocol_ff;
   assign rsp_gradient_value = ograd_ff;
   assign rsp_saturated      = osat_ff;

   // a request is taken only in idle
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |-> state_ff == ST_IDLE)
      else $error("request taken while busy");

   // a held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gradient_value))
      else $error("stalled response changed");

   // saturation flag agrees with the clipped value
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_gradient_value == 32'sh7FFFFFFF || rsp_gradient_value == 32'sh80000000)
      else $error("saturation flag without clip");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the TV denoise gradient unit: directed and random loads and computes, scoreboard.
module tb;
   import tvdg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FrameDim    = 256;
   localparam int unsigned SettleWait  = 400;      // longer than one compute
   localparam longint      CycleLimit  = 3000000;

   typedef struct {
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [31:0] grad;
      logic               sat;
   } grad_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_action;
   logic [7:0]              req_row;
   logic [7:0]              req_col;
   logic signed [PixW-1:0]  req_x_value;
   logic signed [PixW-1:0]  req_b_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [7:0]              rsp_out_row;
   logic [7:0]              rsp_out_col;
   logic signed [GradW-1:0] rsp_gradient_value;
   logic                    rsp_saturated;
   logic                    csr_write;
   logic [3:0]              csr_index;
   logic [15:0]             csr_data;

   // Model copy of the frame store and the register file
   logic signed [17:0] est_px [FrameDim*FrameDim];
   logic signed [17:0] obs_px [FrameDim*FrameDim];
   bit                 px_loaded [FrameDim*FrameDim];
   logic [15:0]        mu_q8;
   logic [15:0]        eps_q16;
   logic [8:0]         rows_cfg;
   logic [8:0]         cols_cfg;

   grad_result_type pending_grads[$];
   int           error_count;
   longint       cycle_count;
   bit           idling_on;
   int           hold_cycles;
   int           rsp_burst;

   tv_denoise_gradient_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_x_value        (req_x_value),
      .req_b_value        (req_b_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_gradient_value (rsp_gradient_value),
      .rsp_saturated      (rsp_saturated),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int unsigned rows_eff();
      return (rows_cfg < FrameDim) ? rows_cfg : FrameDim;
   endfunction

   function automatic int unsigned cols_eff();
      return (cols_cfg < FrameDim) ? cols_cfg : FrameDim;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Hyperbolic smoothed sign z/sqrt(z^2+eps^2): Q8 difference in, Q16 out
   function automatic longint smoothed_sign(longint diff_q8);
      longint unsigned mag;
      longint unsigned z16;
      longint unsigned root;
      longint unsigned quo;
      mag  = (diff_q8 < 0) ? -diff_q8 : diff_q8;
      z16  = mag << 8;
      root = int_sqrt(z16 * z16 + longint'(eps_q16) * longint'(eps_q16));
      // Zero epsilon with zero difference: term is zero
      if (root == 0) return 0;
      quo = ((z16 << 16) + (root >> 1)) / root;
      if (quo > 65536) quo = 65536;
      return (diff_q8 < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   function automatic longint est_at(int unsigned r, int unsigned c);
      return longint'(est_px[r*FrameDim + c]);
   endfunction

   function automatic grad_result_type predict_gradient(int unsigned r, int unsigned c);
      grad_result_type res;
      longint       xc;
      longint       bc;
      longint       hl;
      longint       hr;
      longint       vu;
      longint       vd;
      longint       total;
      xc = est_at(r, c);
      bc = longint'(obs_px[r*FrameDim + c]);
      // Reflect at the top and left borders; repeat the last difference at the far ones
      hl = smoothed_sign(((c > 0) ? est_at(r, c - 1) : xc) - xc);
      hr = (c + 1 < cols_eff()) ? smoothed_sign(xc - est_at(r, c + 1)) : hl;
      vu = smoothed_sign(((r > 0) ? est_at(r - 1, c) : xc) - xc);
      vd = (r + 1 < rows_eff()) ? smoothed_sign(xc - est_at(r + 1, c)) : vu;
      total   = -hl + hr - vu + vd + longint'(mu_q8) * (xc - bc);
      res.row = r[7:0];
      res.col = c[7:0];
      res.sat = 1'b0;
      if (total > 64'sd2147483647) begin
         total   = 64'sd2147483647;
         res.sat = 1'b1;
      end else if (total < -64'sd2147483648) begin
         total   = -64'sd2147483648;
         res.sat = 1'b1;
      end
      res.grad = total[31:0];
      return res;
   endfunction

   // True when every pixel a compute at (r, c) reads has been loaded
   function automatic bit neighbors_loaded(int unsigned r, int unsigned c);
      bit ok;
      ok = px_loaded[r*FrameDim + c];
      if (c > 0)              ok &= px_loaded[r*FrameDim + c - 1];
      if (c + 1 < cols_eff()) ok &= px_loaded[r*FrameDim + c + 1];
      if (r > 0)              ok &= px_loaded[(r-1)*FrameDim + c];
      if (r + 1 < rows_eff()) ok &= px_loaded[(r+1)*FrameDim + c];
      return ok;
   endfunction

   // Response stall: random bursts, plus a long hold-off on request
   always @(negedge clock) begin
      logic stall_next;
      stall_next = 1'b0;
      if (hold_cycles > 0) begin
         stall_next  = 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (rsp_burst > 0) begin
         stall_next = 1'b1;
         rsp_burst  = rsp_burst - 1;
      end else if (idling_on && ($urandom_range(0, 11) == 0)) begin
         stall_next = 1'b1;
         rsp_burst  = $urandom_range(0, 17);
      end
      rsp_stall <= stall_next;
   end

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      grad_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grads.size() == 0) begin
            $display("%0t: unexpected response row %0d col %0d grad %0d", $time,
                     rsp_out_row, rsp_out_col, rsp_gradient_value);
            error_count++;
         end else begin
            exp_res = pending_grads.pop_front();
            if (rsp_out_row !== exp_res.row) begin
               $display("%0t: out_row expected %0d actual %0d", $time, exp_res.row,
                        rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== exp_res.col) begin
               $display("%0t: out_col expected %0d actual %0d", $time, exp_res.col,
                        rsp_out_col);
               error_count++;
            end
            if (rsp_gradient_value !== exp_res.grad) begin
               $display("%0t: gradient_value at (%0d,%0d) expected %0d actual %0d", $time,
                        exp_res.row, exp_res.col, exp_res.grad, rsp_gradient_value);
               error_count++;
            end
            if (rsp_saturated !== exp_res.sat) begin
               $display("%0t: saturated expected %0b actual %0b", $time, exp_res.sat,
                        rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // Drive one request from a falling edge; return at the falling edge after acceptance
   task automatic send_request(logic act, int unsigned r, int unsigned c,
                               logic signed [17:0] xv, logic signed [17:0] bv);
      int unsigned gap;
      if (idling_on && ($urandom_range(0, 9) == 0)) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_row     <= r[7:0];
      req_col     <= c[7:0];
      req_x_value <= xv;
      req_b_value <= bv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Accepted: update the model in request order
      if (r < rows_eff() && c < cols_eff()) begin
         if (act == ACT_LOAD) begin
            est_px[r*FrameDim + c]    = xv;
            obs_px[r*FrameDim + c]    = bv;
            px_loaded[r*FrameDim + c] = 1'b1;
         end else begin
            pending_grads.insert(pending_grads.size(), predict_gradient(r, c));
         end
      end
      @(negedge clock);
   endtask

   task automatic load_pixel(int unsigned r, int unsigned c,
                             logic signed [17:0] xv, logic signed [17:0] bv);
      send_request(ACT_LOAD, r, c, xv, bv);
   endtask

   task automatic compute_at(int unsigned r, int unsigned c);
      send_request(ACT_COMPUTE, r, c, 18'($urandom), 18'($urandom));
   endtask

   // Drain all responses, then let any in-flight load or dropped request finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_grads.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_MU:   mu_q8    = value;
         CSR_EPS:  eps_q16  = value;
         CSR_ROWS: rows_cfg = value[8:0];
         CSR_COLS: cols_cfg = value[8:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] mu, logic [15:0] eps, logic [8:0] rows,
                            logic [8:0] cols);
      wait_idle();
      write_csr(CSR_MU, mu);
      write_csr(CSR_EPS, eps);
      write_csr(CSR_ROWS, {7'd0, rows});
      write_csr(CSR_COLS, {7'd0, cols});
   endtask

   function automatic logic signed [17:0] random_pixel();
      case ($urandom_range(0, 3))
         0:       return 18'sd131071;
         1:       return -18'sd131072;
         2:       return 18'($signed($urandom_range(0, 128)) - 64);
         default: return 18'($urandom);
      endcase
   endfunction

   // Reset defaults, full 256x256 size: corners and the far border
   task automatic test_reset_defaults();
      load_pixel(0, 0, 18'sd131071, -18'sd131072);
      load_pixel(0, 1, -18'sd131072, 18'sd131071);
      load_pixel(1, 0, 18'sd0, 18'sd0);
      load_pixel(0, 2, 18'sd256, -18'sd1);
      load_pixel(1, 1, 18'sd1, 18'sd2);
      compute_at(0, 0);
      compute_at(0, 1);
      load_pixel(255, 255, 18'sd300, 18'sd100);
      load_pixel(254, 255, 18'sd0, 18'sd0);
      load_pixel(255, 254, -18'sd300, 18'sd0);
      compute_at(255, 255);
   endtask

   // Clipping both ways, zero and maximum epsilon
   task automatic test_saturation_and_epsilon();
      configure(16'hFFFF, 16'd0, 9'd2, 9'd2);
      load_pixel(0, 0, 18'sd131071, -18'sd131072);
      load_pixel(0, 1, 18'sd131071, -18'sd131072);
      load_pixel(1, 0, -18'sd131072, 18'sd131071);
      load_pixel(1, 1, 18'sd131071, 18'sd131071);
      compute_at(0, 0);
      compute_at(1, 0);
      compute_at(1, 1);                       // zero difference upward, zero epsilon
      configure(16'd0, 16'hFFFF, 9'd2, 9'd2);
      compute_at(0, 1);
      compute_at(1, 1);
      compute_at(2, 0);                       // outside the rows in use: dropped
      load_pixel(0, 3, 18'sd5, 18'sd5);       // outside: ignored
   endtask

   // Degenerate and oversized shapes
   task automatic test_border_shapes();
      configure(16'd256, 16'd1, 9'd1, 9'd256);
      for (int c = 0; c < 256; c++) load_pixel(0, c, random_pixel(), random_pixel());
      compute_at(0, 0);
      compute_at(0, 255);
      compute_at(0, 128);
      configure(16'd300, 16'd655, 9'd256, 9'd1);
      for (int r = 0; r < 256; r++) load_pixel(r, 0, random_pixel(), random_pixel());
      compute_at(0, 0);
      compute_at(255, 0);
      compute_at(17, 0);
      configure(16'd256, 16'd655, 9'd300, 9'd0);
      compute_at(0, 0);
      load_pixel(3, 3, 18'sd1, 18'sd1);
      configure(16'd256, 16'd655, 9'd0, 9'd511);
      compute_at(0, 5);
   endtask

   // Random phases: mostly computes on small frames, some noise outside the size
   task automatic test_random_frames();
      int unsigned r;
      int unsigned c;
      logic [15:0] mu;
      logic [15:0] eps;
      logic        act;
      for (int phase = 0; phase < 9; phase++) begin
         mu  = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                           : 16'($urandom_range(0, 1023));
         eps = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF)
                                           : 16'($urandom);
         configure(mu, eps, 9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)));
         // Last stretch runs without any idling
         if (phase == 8) idling_on = 1'b0;
         // Hold the response channel off so the unit backs up into its input
         if (phase == 3) hold_cycles = 3000;
         for (int n = 0; n < 80; n++) begin
            if ($urandom_range(0, 19) == 0) begin
               r   = $urandom_range(0, 255);
               c   = $urandom_range(0, 255);
               act = logic'($urandom_range(0, 1));
               // An in-frame compute needs a fully loaded neighborhood
               if (act == ACT_COMPUTE && r < rows_eff() && c < cols_eff() &&
                   !neighbors_loaded(r, c))
                  act = ACT_LOAD;
               send_request(act, r, c, random_pixel(), random_pixel());
            end else begin
               r = $urandom_range(0, rows_eff() - 1);
               c = $urandom_range(0, cols_eff() - 1);
               if ($urandom_range(0, 9) < 7 && neighbors_loaded(r, c))
                  compute_at(r, c);
               else
                  load_pixel(r, c, random_pixel(), random_pixel());
            end
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_action  = ACT_LOAD;
      req_row     = '0;
      req_col     = '0;
      req_x_value = '0;
      req_b_value = '0;
      rsp_stall   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = CSR_MU;
      csr_data    = '0;
      error_count = 0;
      cycle_count = 0;
      hold_cycles = 0;
      rsp_burst   = 0;
      idling_on   = 1'b1;
      mu_q8       = 16'd256;
      eps_q16     = 16'd655;
      rows_cfg    = 9'd256;
      cols_cfg    = 9'd256;
      foreach (px_loaded[i]) px_loaded[i] = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_saturation_and_epsilon();
      test_border_shapes();
      test_random_frames();

      wait_idle();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
